// File: design/rlh_pkg.sv
// Package for the reuse latency histogram: payload structs, codes and sizes.
// No dependencies.
`timescale 1ns / 1ps
package rlh_pkg;
	localparam int LinearBuckets = 1024;
	localparam int MaxNodes = 64;
	localparam int NumBuckets = LinearBuckets + 2;
	localparam int NumCounters = 6;
	localparam int BktW = $clog2(NumBuckets);
	localparam int CntIdxW = 3;

	typedef enum logic [1:0] {
		CMD_RECORD = 2'd0,
		CMD_READ_BKT = 2'd1,
		CMD_READ_CNT = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		ST_RECORDED = 3'd0,
		ST_DISABLED = 3'd1,
		ST_NULL = 3'd2,
		ST_NO_BAL = 3'd3,
		ST_UNTRACKED = 3'd4,
		ST_READ_OK = 3'd5,
		ST_CLEARED = 3'd6,
		ST_BAD_INDEX = 3'd7
	} status_t;

	localparam logic [CntIdxW-1:0] CNT_TOTAL = 3'd0;
	localparam logic [CntIdxW-1:0] CNT_RECORDED = 3'd1;
	localparam logic [CntIdxW-1:0] CNT_DISABLED = 3'd2;
	localparam logic [CntIdxW-1:0] CNT_NULL = 3'd3;
	localparam logic [CntIdxW-1:0] CNT_NO_BAL = 3'd4;
	localparam logic [CntIdxW-1:0] CNT_UNTRACKED = 3'd5;

	localparam logic [1:0] REG_ENABLE = 2'd0;
	localparam logic [1:0] REG_MASK = 2'd1;
	localparam logic [1:0] REG_QUANTUM = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [31:0] reuse_ms;
		logic signed [7:0] src_node;
		logic task_present;
		logic page_present;
		logic signed [3:0] balancing_mode;
		logic [10:0] index;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [10:0] bucket;
		logic [63:0] read_value;
	} out_item_t;
endpackage

// File: design/rlh_divider.sv
// Bit-serial restoring divider: ceil(dividend / divisor), one quotient bit a cycle.
// Does not depend on rlh_pkg; stand-alone.
`timescale 1ns / 1ps
module rlh_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        go,
	input  logic [31:0] dividend,
	input  logic [9:0]  divisor,
	output logic        done,
	output logic [32:0] quotient
);
	logic [32:0] num_q;
	logic [10:0] rem_q;
	logic [9:0]  div_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [10:0] trial;
	logic [10:0] diff;

	assign trial = {rem_q[9:0], num_q[32]};
	assign diff  = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd33;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// numerator is dividend + divisor - 1, so the floor is the ceiling
	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= {1'b0, dividend} + {23'd0, divisor} - 33'd1;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			if (!diff[10]) begin
				rem_q <= diff;
				num_q <= {num_q[31:0], 1'b1};
			end else begin
				rem_q <= trial;
				num_q <= {num_q[31:0], 1'b0};
			end
		end
	end

	assign quotient = num_q;
endmodule

// File: design/reuse_latency_histogram_core.sv
// Reuse latency histogram top level: APB registers, filter, serial divider, bucket RAM.
// Depends on rlh_pkg and rlh_divider.
// Sequence from the accepting edge to the result: a passing record goes through the go
// register, the 33 divider steps, done and a RAM read-modify-write (S_INC, S_RD, S_WR); a
// bucket read through S_RD and S_WR; a counter read or a filtered record is registered at
// the accepting edge; clear sweeps every bucket, one bucket per cycle. Throughput: one item at a time, taken in idle.
// Reset: clears the counters and sweeps all 1026 buckets of the RAM to zero with busy high; registers
// return to enable 1, mask 0, quantum 4. Results cannot be stalled.
`timescale 1ns / 1ps
module reuse_latency_histogram_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  rlh_pkg::in_item_t  in_item,
	output logic               result_valid,
	output rlh_pkg::out_item_t result
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV, S_RD, S_INC, S_WR
	} state_t;

	state_t state_q;
	logic        enable_q;
	logic [63:0] mask_q;
	logic [9:0]  quantum_q;
	logic [63:0] cnt_q [rlh_pkg::NumCounters];
	logic [63:0] mem [rlh_pkg::NumBuckets];
	logic [rlh_pkg::BktW-1:0] addr_q;
	logic [63:0] rdata_q;
	logic [63:0] sum_q;
	rlh_pkg::in_item_t item_q;
	logic        clr_resp_q;
	logic        go_q;
	logic        div_go, div_done;
	logic [32:0] quot;
	logic [9:0]  q_eff;
	logic        wr_en;
	logic [63:0] wr_data;
	logic [rlh_pkg::BktW-1:0] bkt_sel;
	logic [2:0] reg_idx;
	logic       nd_ok;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3] == 2'd3 ? 3'd3 : {1'b0, paddr[4:3]};

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			{1'b0, rlh_pkg::REG_ENABLE}:  prdata = {63'd0, enable_q};
			{1'b0, rlh_pkg::REG_MASK}:    prdata = mask_q;
			{1'b0, rlh_pkg::REG_QUANTUM}: prdata = {54'd0, quantum_q};
			default:                      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			mask_q    <= '0;
			quantum_q <= 10'd4;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				{1'b0, rlh_pkg::REG_ENABLE}:  enable_q  <= pwdata[0];
				{1'b0, rlh_pkg::REG_MASK}:    mask_q    <= pwdata;
				{1'b0, rlh_pkg::REG_QUANTUM}: quantum_q <= pwdata[9:0];
				default: ;
			endcase
		end
	end

	assign q_eff = (quantum_q == '0) ? 10'd1 : quantum_q;
	assign busy  = state_q != S_IDLE;

	// node test: non-negative, below MaxNodes, mask bit set
	assign nd_ok = !in_item.src_node[7] && (in_item.src_node[6:0] < 7'(rlh_pkg::MaxNodes))
		&& mask_q[in_item.src_node[5:0]];

	rlh_divider u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(item_q.reuse_ms),
		.divisor(q_eff), .done(div_done), .quotient(quot)
	);

	always_comb begin
		if (item_q.reuse_ms == '0) bkt_sel = '0;
		else if (quot <= 33'(rlh_pkg::LinearBuckets)) bkt_sel = quot[rlh_pkg::BktW-1:0];
		else bkt_sel = rlh_pkg::BktW'(rlh_pkg::LinearBuckets + 1);
	end

	assign wr_en   = state_q == S_CLEAR ||
		(state_q == S_WR && item_q.cmd != rlh_pkg::CMD_READ_BKT);
	assign wr_data = state_q == S_CLEAR ? 64'd0 : sum_q;

	// bucket memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (wr_en) mem[addr_q] <= wr_data;
		rdata_q <= mem[addr_q];
	end

	assign div_go = go_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			addr_q       <= '0;
			result_valid <= 1'b0;
			result       <= '0;
			item_q       <= '0;
			clr_resp_q   <= 1'b0;
			go_q         <= 1'b0;
			for (int i = 0; i < rlh_pkg::NumCounters; i++) cnt_q[i] <= '0;
		end else begin
			result_valid <= 1'b0;
			go_q         <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					if (addr_q == rlh_pkg::BktW'(rlh_pkg::NumBuckets - 1)) begin
						state_q <= S_IDLE;
						addr_q  <= '0;
						if (clr_resp_q) begin
							result_valid  <= 1'b1;
							result.status <= rlh_pkg::ST_CLEARED;
							result.bucket <= '0;
							result.read_value <= '0;
							clr_resp_q    <= 1'b0;
						end
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (start) begin
						item_q <= in_item;
						unique case (in_item.cmd)
							rlh_pkg::CMD_RECORD: begin
								cnt_q[rlh_pkg::CNT_TOTAL] <= cnt_q[rlh_pkg::CNT_TOTAL] + 1'b1;
								result_valid <= 1'b1;
								result.bucket     <= '0;
								result.read_value <= '0;
								if (!enable_q) begin
									cnt_q[rlh_pkg::CNT_DISABLED] <= cnt_q[rlh_pkg::CNT_DISABLED] + 1'b1;
									result.status <= rlh_pkg::ST_DISABLED;
								end else if (!in_item.task_present || !in_item.page_present) begin
									cnt_q[rlh_pkg::CNT_NULL] <= cnt_q[rlh_pkg::CNT_NULL] + 1'b1;
									result.status <= rlh_pkg::ST_NULL;
								end else if (in_item.balancing_mode <= 4'sd0) begin
									cnt_q[rlh_pkg::CNT_NO_BAL] <= cnt_q[rlh_pkg::CNT_NO_BAL] + 1'b1;
									result.status <= rlh_pkg::ST_NO_BAL;
								end else if (!nd_ok) begin
									cnt_q[rlh_pkg::CNT_UNTRACKED] <= cnt_q[rlh_pkg::CNT_UNTRACKED] + 1'b1;
									result.status <= rlh_pkg::ST_UNTRACKED;
								end else begin
									result_valid <= 1'b0;
									go_q    <= 1'b1;
									state_q <= S_DIV;
								end
							end
							rlh_pkg::CMD_READ_BKT: begin
								result.bucket     <= '0;
								result.read_value <= '0;
								if (in_item.index < 11'(rlh_pkg::NumBuckets)) begin
									addr_q  <= in_item.index[rlh_pkg::BktW-1:0];
									state_q <= S_RD;
								end else begin
									result_valid  <= 1'b1;
									result.status <= rlh_pkg::ST_BAD_INDEX;
								end
							end
							rlh_pkg::CMD_READ_CNT: begin
								result_valid  <= 1'b1;
								result.bucket <= '0;
								if (in_item.index < 11'(rlh_pkg::NumCounters)) begin
									result.status     <= rlh_pkg::ST_READ_OK;
									result.read_value <= cnt_q[in_item.index[2:0]];
								end else begin
									result.status     <= rlh_pkg::ST_BAD_INDEX;
									result.read_value <= '0;
								end
							end
							default: begin
								for (int i = 0; i < rlh_pkg::NumCounters; i++) cnt_q[i] <= '0;
								addr_q     <= '0;
								clr_resp_q <= 1'b1;
								state_q    <= S_CLEAR;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						addr_q  <= bkt_sel;
						state_q <= S_INC;
					end
				end
				S_RD: state_q <= S_WR;
				S_INC: state_q <= S_RD;
				S_WR: begin
					// S_RD doubles as the wait for read data; sum_q is ready here
					result_valid <= 1'b1;
					if (item_q.cmd == rlh_pkg::CMD_READ_BKT) begin
						result.status     <= rlh_pkg::ST_READ_OK;
						result.read_value <= rdata_q;
					end else begin
						result.status <= rlh_pkg::ST_RECORDED;
						result.bucket <= 11'(addr_q);
						cnt_q[rlh_pkg::CNT_RECORDED] <= cnt_q[rlh_pkg::CNT_RECORDED] + 1'b1;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// increment lands in sum_q in the cycle after the read data; reads never write it back
	always_ff @(posedge clk) begin
		sum_q <= rdata_q + 64'd1;
	end
endmodule
